### hdl/fts_pkg.sv
package fts_pkg;

    localparam int TIME_WIDTH_DEF     = 32;
    localparam int RATE_WINDOW_MS_DEF = 1000;

    localparam int STEP_W       = 16;
    localparam int ACC_W        = 17;
    localparam int RATE_DIVIDEND = 1000;
    localparam int DIV_BITS     = $clog2(RATE_DIVIDEND + 1);
    localparam int DIV_CNT_W    = $clog2(DIV_BITS);
    localparam int MAX_OUT      = 64;
    localparam int STEP_CNT_W   = $clog2(MAX_OUT);
    localparam int MIN_MAX_STEP = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [1:0] CMD_FRAME_BEGIN = 2'd0;
    localparam logic [1:0] CMD_FRAME_END   = 2'd1;
    localparam logic [1:0] CMD_REQUEST     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] time_ms;
    } evt_item_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_ms;
        logic              no_step;
        logic              last;
    } res_item_t;

    typedef struct packed {
        logic [STEP_W-1:0] min_step;
        logic [STEP_W-1:0] max_eff;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] delta;
    } q_entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [STEP_W-1:0] delta;
    } q_stat_t;

endpackage

### hdl/fts_front.sv
module fts_front
    import fts_pkg::*;
#(
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int RATE_WINDOW_MS = RATE_WINDOW_MS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      evt_valid,
    output logic      evt_ready,
    input  evt_item_t evt,
    input  cfg_t      cfg,
    input  q_stat_t   q_stat,
    output q_entry_t  q_push
);

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    localparam logic [TIME_WIDTH-1:0] WINDOW = TIME_WIDTH'(RATE_WINDOW_MS);
    localparam logic [DIV_BITS-1:0]   DIVIDEND = DIV_BITS'(RATE_DIVIDEND);

    state_t                state_reg, state_next;
    logic [TIME_WIDTH-1:0] frame_start_reg, frame_start_next;
    logic [TIME_WIDTH-1:0] window_start_reg, window_start_next;
    logic [STEP_W-1:0]     frame_cnt_reg, frame_cnt_next;
    logic [STEP_W-1:0]     rate_reg, rate_next;
    logic [STEP_W-1:0]     measured_reg, measured_next;
    logic [STEP_W:0]       rem_reg, rem_next;
    logic [DIV_BITS-1:0]   dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]   quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    logic                  accept;
    logic [TIME_WIDTH-1:0] t;
    logic [TIME_WIDTH-1:0] since_window;
    logic [TIME_WIDTH-1:0] frame_len;
    logic [TIME_WIDTH-1:0] mx_wide;
    logic [STEP_W:0]       rem_sh;
    logic                  div_ge;

    assign evt_ready    = (state_reg == ST_IDLE) && !q_stat.full;
    assign accept       = evt_valid && evt_ready;
    assign t            = TIME_WIDTH'(evt.time_ms);
    assign since_window = t - window_start_reg;
    assign frame_len    = t - frame_start_reg;
    assign mx_wide      = TIME_WIDTH'(cfg.max_eff);
    assign rem_sh       = {rem_reg[STEP_W-1:0], dvd_reg[DIV_BITS-1]};
    assign div_ge       = rem_sh >= {1'b0, rate_reg};

    always_comb
    begin
        state_next        = state_reg;
        frame_start_next  = frame_start_reg;
        window_start_next = window_start_reg;
        frame_cnt_next    = frame_cnt_reg;
        rate_next         = rate_reg;
        measured_next     = measured_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        quot_next         = quot_reg;
        cnt_next          = cnt_reg;
        q_push            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (evt.command)
                        CMD_FRAME_BEGIN:
                        begin
                            frame_start_next = t;
                            if (since_window > WINDOW)
                            begin
                                window_start_next = t;
                                rate_next         = frame_cnt_reg;
                                frame_cnt_next    = STEP_W'(1);
                            end
                            else if (frame_cnt_reg != '1)
                            begin
                                frame_cnt_next = frame_cnt_reg + STEP_W'(1);
                            end
                        end
                        CMD_FRAME_END:
                        begin
                            if (frame_len > mx_wide)
                                measured_next = cfg.max_eff;
                            else
                                measured_next = frame_len[STEP_W-1:0];
                        end
                        CMD_REQUEST:
                        begin
                            if (rate_reg == '0)
                            begin
                                q_push.valid = 1'b1;
                                q_push.delta = measured_reg;
                            end
                            else
                            begin
                                rem_next   = '0;
                                dvd_next   = DIVIDEND;
                                quot_next  = '0;
                                cnt_next   = DIV_CNT_W'(DIV_BITS - 1);
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? (rem_sh - {1'b0, rate_reg}) : rem_sh;
                dvd_next  = {dvd_reg[DIV_BITS-2:0], 1'b0};
                quot_next = {quot_reg[DIV_BITS-2:0], div_ge};
                cnt_next  = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    q_push.valid = 1'b1;
                    q_push.delta = STEP_W'(quot_next);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_start_reg  <= '0;
            window_start_reg <= '0;
            frame_cnt_reg    <= '0;
            rate_reg         <= '0;
            measured_reg     <= '0;
            rem_reg          <= '0;
            dvd_reg          <= '0;
            quot_reg         <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_start_reg  <= frame_start_next;
            window_start_reg <= window_start_next;
            frame_cnt_reg    <= frame_cnt_next;
            rate_reg         <= rate_next;
            measured_reg     <= measured_next;
            rem_reg          <= rem_next;
            dvd_reg          <= dvd_next;
            quot_reg         <= quot_next;
            cnt_reg          <= cnt_next;
        end
    end

endmodule

### hdl/fts_queue.sv
module fts_queue
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t q_push,
    input  logic     q_pop,
    output q_stat_t  q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [STEP_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_stat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign q_stat.delta = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (q_push.valid && !q_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!q_push.valid && q_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
            mem[wr_ptr_reg] <= q_push.delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push.valid && q_stat.full && !q_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_stat.empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### hdl/fts_back.sv
module fts_back
    import fts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  q_stat_t   q_stat,
    output logic      q_pop,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                state_reg, state_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [STEP_CNT_W-1:0] n_reg, n_next;
    logic                  res_valid_reg, res_valid_next;
    res_item_t             res_reg, res_next;

    logic                  can_load;
    logic                  load;
    res_item_t             load_item;
    logic [ACC_W-1:0]      mx_w;
    logic [ACC_W-1:0]      min_w;
    logic [ACC_W-1:0]      acc_less_mx;
    logic                  last_full;

    assign res_valid   = res_valid_reg;
    assign res         = res_reg;
    assign can_load    = !res_valid_reg || res_ready;
    assign mx_w        = ACC_W'(cfg.max_eff);
    assign min_w       = ACC_W'(cfg.min_step);
    assign acc_less_mx = acc_reg - mx_w;
    assign last_full   = (n_reg == STEP_CNT_W'(MAX_OUT - 1)) ||
                         ((acc_less_mx < mx_w) && (acc_less_mx <= min_w));

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        load_item  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    acc_next   = acc_reg + ACC_W'(q_stat.delta);
                    n_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    if ((n_reg == '0) && (acc_reg < min_w))
                    begin
                        load_item.no_step = 1'b1;
                        load_item.last    = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else if (acc_reg >= mx_w)
                    begin
                        load_item.step_ms = cfg.max_eff;
                        load_item.last    = last_full;
                        acc_next          = acc_less_mx;
                        n_next            = n_reg + STEP_CNT_W'(1);
                        if (last_full)
                            state_next = ST_IDLE;
                    end
                    else if (acc_reg > min_w)
                    begin
                        load_item.step_ms = acc_reg[STEP_W-1:0];
                        load_item.last    = 1'b1;
                        acc_next          = '0;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        load_item.no_step = 1'b1;
                        load_item.last    = 1'b1;
                        state_next        = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_valid_next = load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
        res_next       = load ? load_item : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            n_reg         <= n_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.no_step |-> res_reg.last && (res_reg.step_ms == '0))
        else $error("marker item malformed");
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.no_step |-> res_reg.step_ms != '0)
        else $error("zero-length step emitted");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        load && load_item.last |=> state_reg == ST_IDLE)
        else $error("run continues after last item");
`endif

endmodule

### hdl/fixed_timestep_splitter_top.sv
// Fixed-timestep splitter. Frame events (begin, end) are handled in the front
// end and give no result; a frame-begin also rolls the frame-rate window. A step
// request is queued directly by the front end while the latched frame rate is
// zero, otherwise after the 10-iteration restoring divider that forms 1000/rate.
// The back end then adds the step time to the accumulator and gives one result
// item per cycle (1 to 64) while the output register can take it; a two-entry
// queue lets the front end take further items meanwhile. Results leave through
// an output register. Configuration writes are taken at any cycle.
module fixed_timestep_splitter_top
    import fts_pkg::*;
#(
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
    parameter int RATE_WINDOW_MS = RATE_WINDOW_MS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    output logic                   evt_ready,
    input  evt_item_t              evt,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_item_t              res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]      cfg_data
);

    logic [STEP_W-1:0] min_step_reg;
    logic [STEP_W-1:0] max_step_reg;
    cfg_t              cfg;
    q_entry_t          q_push;
    q_stat_t           q_stat;
    logic              q_pop;

    assign cfg_ready    = 1'b1;
    assign cfg.min_step = min_step_reg;
    assign cfg.max_eff  = (max_step_reg < STEP_W'(MIN_MAX_STEP)) ?
                          STEP_W'(MIN_MAX_STEP) : max_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_step_reg <= '0;
            max_step_reg <= STEP_W'(MIN_MAX_STEP);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_STEP: min_step_reg <= cfg_data;
                REG_MAX_STEP: max_step_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fts_front #(
        .TIME_WIDTH     (TIME_WIDTH),
        .RATE_WINDOW_MS (RATE_WINDOW_MS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    fts_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_stat (q_stat)
    );

    fts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### test/fixed_timestep_splitter_checker.sv
module fixed_timestep_splitter_checker
    import fts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    input  logic                   evt_ready,
    input  evt_item_t              evt,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  res_item_t              res,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]      cfg_data,
    output int unsigned            error_count,
    output int unsigned            pending_count,
    output int unsigned            result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_CAP = 40;

    logic [STEP_W-1:0] min_step_cfg;
    logic [STEP_W-1:0] max_step_cfg;
    logic [31:0]       frame_begin_ms;
    logic [31:0]       window_begin_ms;
    logic [15:0]       frames_in_window;
    logic [15:0]       frame_rate;
    logic [STEP_W-1:0] frame_len_ms;
    logic [ACC_W-1:0]  acc_ms;
    res_item_t         expected_steps[$];
    int unsigned       mismatches;
    int unsigned       steps_seen;

    task automatic report_mismatch(input string what, input logic [STEP_W-1:0] got,
                                   input logic [STEP_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_step(input logic [STEP_W-1:0] len, input logic marker,
                             input logic fin);
        res_item_t r;
        r.step_ms = len;
        r.no_step = marker;
        r.last    = fin;
        expected_steps = {expected_steps, r};
    endtask

    task automatic predict_event(input evt_item_t it);
        logic [31:0]       elapsed;
        logic [STEP_W-1:0] step_len;
        logic [STEP_W-1:0] delta;
        int unsigned       full;
        int unsigned       rem;
        int unsigned       total;
        int unsigned       k;
        step_len = (max_step_cfg < MIN_MAX_STEP) ? STEP_W'(MIN_MAX_STEP) : max_step_cfg;
        case (it.command)
            CMD_FRAME_BEGIN:
            begin
                frame_begin_ms = it.time_ms;
                elapsed = it.time_ms - window_begin_ms;
                if (elapsed > RATE_WINDOW_MS_DEF)
                begin
                    window_begin_ms  = it.time_ms;
                    frame_rate       = frames_in_window;
                    frames_in_window = '0;
                end
                if (frames_in_window != 16'hFFFF)
                    frames_in_window = frames_in_window + 16'd1;
            end
            CMD_FRAME_END:
            begin
                elapsed = it.time_ms - frame_begin_ms;
                if (elapsed > step_len)
                    elapsed = 32'(step_len);
                frame_len_ms = elapsed[STEP_W-1:0];
            end
            CMD_REQUEST:
            begin
                delta = (frame_rate != 0) ? STEP_W'(RATE_DIVIDEND / frame_rate) : frame_len_ms;
                acc_ms = acc_ms + ACC_W'(delta);
                total = 0;
                if (acc_ms >= min_step_cfg)
                begin
                    full = acc_ms / step_len;
                    rem  = acc_ms % step_len;
                    if (full >= MAX_OUT)
                    begin
                        total = MAX_OUT;
                        for (k = 0; k < MAX_OUT; k++)
                            push_step(step_len, 1'b0, k + 1 == MAX_OUT);
                        acc_ms = acc_ms - ACC_W'(MAX_OUT * step_len);
                    end
                    else
                    begin
                        total = full + ((rem > min_step_cfg) ? 1 : 0);
                        for (k = 0; k < full; k++)
                            push_step(step_len, 1'b0, k + 1 == total);
                        if (rem > min_step_cfg)
                        begin
                            push_step(STEP_W'(rem), 1'b0, 1'b1);
                            acc_ms = '0;
                        end
                        else
                        begin
                            acc_ms = ACC_W'(rem);
                        end
                    end
                end
                if (total == 0)
                    push_step('0, 1'b1, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_step(input res_item_t got);
        res_item_t want;
        if (expected_steps.size() == 0)
        begin
            report_mismatch("unexpected step item", got.step_ms, '0);
        end
        else
        begin
            want = expected_steps.pop_front();
            if (got.step_ms !== want.step_ms)
                report_mismatch("step_ms", got.step_ms, want.step_ms);
            if (got.no_step !== want.no_step)
                report_mismatch("no_step", STEP_W'(got.no_step), STEP_W'(want.no_step));
            if (got.last !== want.last)
                report_mismatch("last", STEP_W'(got.last), STEP_W'(want.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            min_step_cfg     = '0;
            max_step_cfg     = STEP_W'(MIN_MAX_STEP);
            frame_begin_ms   = '0;
            window_begin_ms  = '0;
            frames_in_window = '0;
            frame_rate       = '0;
            frame_len_ms     = '0;
            acc_ms           = '0;
            expected_steps.delete();
            mismatches       = 0;
            steps_seen       = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MIN_STEP)
                    min_step_cfg = cfg_data;
                else if (cfg_index == REG_MAX_STEP)
                    max_step_cfg = cfg_data;
            end
            if (res_valid && res_ready)
            begin
                steps_seen++;
                check_step(res);
            end
            if (evt_valid && evt_ready)
                predict_event(evt);
        end
        error_count   <= mismatches;
        pending_count <= expected_steps.size();
        result_count  <= steps_seen;
    end

endmodule

### test/fixed_timestep_splitter_top_tb.sv
module fixed_timestep_splitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fts_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned DRAIN_CYCLES    = 100;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned PHASE_ITEMS     = 112;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   evt_valid = 1'b0;
    logic                   evt_ready;
    evt_item_t              evt       = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    res_item_t              res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]      cfg_data  = '0;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned result_count;
    int unsigned items_sent  = 0;
    int unsigned cfg_writes  = 0;
    int unsigned cycle_count = 0;
    logic [31:0] now         = '0;
    bit          no_idle     = 1'b0;
    bit          hold_go     = 1'b0;
    bit          holding     = 1'b0;

    fixed_timestep_splitter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fixed_timestep_splitter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt_valid     (evt_valid),
        .evt_ready     (evt_ready),
        .evt           (evt),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        res_ready <= !holding && (no_idle || $urandom_range(99) >= 12);

    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fixed_timestep_splitter_top test failed");
        $finish;
    end

    task automatic send_item(input evt_item_t it);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 12)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= it;
        @(posedge clk);
        while (!evt_ready) @(posedge clk);
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] stamp);
        evt_item_t it;
        it.command = cmd;
        it.time_ms = stamp;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        evt_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [STEP_W-1:0] min_val, input logic [STEP_W-1:0] max_val);
        wait_drained();
        write_reg(REG_MIN_STEP, min_val);
        write_reg(REG_MAX_STEP, max_val);
    endtask

    task automatic run_random_phase(input int unsigned target, input int unsigned frame_lo,
                                    input int unsigned frame_hi, input bit with_hold);
        int unsigned first;
        int unsigned reqs;
        evt_item_t   noise;
        first = items_sent;
        while (items_sent - first < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_cmd(CMD_FRAME_BEGIN, now);
                if ($urandom_range(19) == 0)
                    now = now + $urandom_range(0, 70000);
                else
                    now = now + $urandom_range(frame_lo, frame_hi);
                if ($urandom_range(9) != 0)
                    send_cmd(CMD_FRAME_END, now);
                reqs = $urandom_range(1, 2);
                repeat (reqs) send_cmd(CMD_REQUEST, now);
            end
            else
            begin
                noise.command = 2'($urandom_range(3));
                noise.time_ms = ($urandom_range(1) != 0) ? $urandom : now;
                send_item(noise);
            end
            if (with_hold && !hold_go && items_sent - first >= 20)
                hold_go = 1'b1;
        end
    endtask

    initial
    begin : stimulus
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        set_config(16'd0, 16'd16);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
        send_cmd(CMD_REQUEST, 32'd0);
        send_cmd(CMD_FRAME_BEGIN, 32'd0);
        send_cmd(CMD_FRAME_END, 32'd10);
        send_cmd(CMD_REQUEST, 32'd10);

        set_config(16'd0, 16'd0);
        send_cmd(CMD_FRAME_END, 32'hFFFF_FFFF);
        send_cmd(CMD_REQUEST, 32'hFFFF_FFFF);

        set_config(16'hFFFF, 16'hFFFF);
        send_cmd(CMD_FRAME_END, 32'hFFFF_FFFF);
        send_cmd(CMD_REQUEST, 32'hFFFF_FFFF);
        send_cmd(CMD_REQUEST, 32'hFFFF_FFFF);
        send_cmd(CMD_FRAME_END, 32'd5);
        send_cmd(CMD_REQUEST, 32'd5);

        set_config(16'd2000, 16'd15);
        send_cmd(CMD_FRAME_BEGIN, 32'hFFFF_FFFF);
        repeat (4) send_cmd(CMD_REQUEST, 32'hFFFF_FFFF);

        now = 32'd2001;

        set_config(16'($urandom_range(0, 8)), 16'($urandom_range(16, 40)));
        run_random_phase(PHASE_ITEMS, 10, 40, 1'b1);

        now = 32'hFFFF_F000;
        no_idle = 1'b1;
        set_config(16'd0, 16'($urandom_range(0, 15)));
        run_random_phase(PHASE_ITEMS, 1, 5, 1'b0);
        no_idle = 1'b0;

        set_config(16'($urandom_range(20, 3000)), 16'($urandom_range(16, 100)));
        run_random_phase(PHASE_ITEMS, 2, 60, 1'b0);

        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random_phase(PHASE_ITEMS, 0, 200, 1'b0);

        wait_drained();
        @(negedge clk);
        $display("run covered %0d event items, %0d step items and %0d register writes,",
                 items_sent, result_count, cfg_writes);
        $display("including timestamp wraparound, overflow bursts and a long output stall");
        if (error_count == 0)
            $display("fixed_timestep_splitter_top test passed");
        else
            $display("fixed_timestep_splitter_top test failed");
        $finish;
    end

endmodule
